### rtl/rdt_pkg.sv
// Package for the row distance transform block: sizes, register indexes,
// controller states, command/status structs and the saturating increment.
// No dependencies.
package rdt_pkg;

  localparam int MAX_ROW    = 64;
  localparam int LABEL_BITS = 8;

  // stored label width: labels arrive in 8 bits, only LABEL_BITS are kept
  localparam int LAB_W  = (LABEL_BITS < 8) ? LABEL_BITS : 8;
  localparam int IDX_W  = $clog2(MAX_ROW);
  localparam int ROW_W  = 7;   // row_length register and row counters
  localparam int DIST_W = 7;   // stored distance, all ones is infinity

  localparam logic [DIST_W-1:0] DIST_INF = '1;

  localparam logic [1:0] CFG_MULTIREGION = 2'd0;
  localparam logic [1:0] CFG_TORIC       = 2'd1;
  localparam logic [1:0] CFG_ROW_LENGTH  = 2'd2;

  typedef enum logic [3:0] {
    S_LOAD,
    S_FWD_RD,
    S_FWD_EX,
    S_FLUSH,
    S_BWD_RD0,
    S_BWD_INIT,
    S_BWD_RD,
    S_BWD_EX,
    S_OUT_RD,
    S_OUT_LD
  } rdt_state_e;

  typedef struct packed {
    logic load_wr;    // store incoming label
    logic lab_rd;     // read label at current index
    logic dist_rd;    // read distance
    logic rd_nxt;     // distance read at index+1 (mod n) instead of index
    logic fwd_step;   // one forward scan element
    logic flush;      // write the pending forward value, set up backward scan
    logic bwd_init;   // take the seed distance of the backward scan
    logic bwd_step;   // one backward scan element
    logic out_init;   // rewind index for emission
    logic out_load;   // load output register
  } rdt_cmd_t;

  typedef struct packed {
    logic load_last;  // incoming label ends the row
    logic fwd_last;   // this forward element ends the scan
    logic n_one;      // row of one voxel
    logic bwd_last;   // this backward element ends the scan
    logic out_last;   // this result ends the row
    logic out_free;   // output register can take a result
  } rdt_status_t;

  function automatic logic [DIST_W-1:0] inc_sat(input logic [DIST_W-1:0] d);
    if (d >= DIST_INF - DIST_W'(1)) begin
      return DIST_INF;
    end
    return d + DIST_W'(1);
  endfunction

endpackage

### rtl/rdt_ctrl.sv
// Controller of the row distance transform: sequences load, forward scan,
// backward scan and emission. Uses rdt_pkg.
module rdt_ctrl
  import rdt_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_valid_i,
  output logic        s_ready_o,
  input  rdt_status_t status_i,
  output rdt_cmd_t    cmd_o
);

  rdt_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_LOAD: begin
        if (s_valid_i && status_i.load_last) state_d = S_FWD_RD;
      end
      S_FWD_RD:   state_d = S_FWD_EX;
      S_FWD_EX:   state_d = status_i.fwd_last ? S_FLUSH : S_FWD_RD;
      S_FLUSH:    state_d = status_i.n_one ? S_OUT_RD : S_BWD_RD0;
      S_BWD_RD0:  state_d = S_BWD_INIT;
      S_BWD_INIT: state_d = S_BWD_RD;
      S_BWD_RD:   state_d = S_BWD_EX;
      S_BWD_EX:   state_d = status_i.bwd_last ? S_OUT_RD : S_BWD_RD;
      S_OUT_RD:   state_d = S_OUT_LD;
      S_OUT_LD: begin
        if (status_i.out_free) state_d = status_i.out_last ? S_LOAD : S_OUT_RD;
      end
      default:    state_d = S_LOAD;
    endcase
  end

  always_comb begin
    cmd_o     = '0;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_LOAD: begin
        s_ready_o     = 1'b1;
        cmd_o.load_wr = s_valid_i;
      end
      S_FWD_RD:   cmd_o.lab_rd = 1'b1;
      S_FWD_EX:   cmd_o.fwd_step = 1'b1;
      S_FLUSH: begin
        cmd_o.flush    = 1'b1;
        cmd_o.out_init = status_i.n_one;
      end
      S_BWD_RD0: begin
        cmd_o.dist_rd = 1'b1;
        cmd_o.rd_nxt  = 1'b1;
      end
      S_BWD_INIT: cmd_o.bwd_init = 1'b1;
      S_BWD_RD:   cmd_o.dist_rd = 1'b1;
      S_BWD_EX: begin
        cmd_o.bwd_step = 1'b1;
        cmd_o.out_init = status_i.bwd_last;
      end
      S_OUT_RD:   cmd_o.dist_rd = 1'b1;
      S_OUT_LD:   cmd_o.out_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

### rtl/rdt_datapath.sv
// Datapath of the row distance transform: config registers, label and
// distance stores, scan registers and the output register. Uses rdt_pkg.
module rdt_datapath
  import rdt_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [ROW_W-1:0]  cfg_wdata_i,
  input  logic [7:0]        label_i,
  input  rdt_cmd_t          cmd_i,
  output rdt_status_t       status_o,
  input  logic              out_ready_i,
  output logic              out_valid_o,
  output logic [5:0]        out_dist_o,
  output logic              out_inf_o,
  output logic              out_last_o
);

  logic [LAB_W-1:0]  label_mem [MAX_ROW];
  logic [DIST_W-1:0] dist_mem  [MAX_ROW];

  logic              multi_q, toric_q;
  logic [ROW_W-1:0]  row_len_q;

  logic [ROW_W-1:0]  count_q, count_d;
  logic [ROW_W-1:0]  n_q, n_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [IDX_W-1:0]  prev_q, prev_d;
  logic [ROW_W-1:0]  steps_q, steps_d;
  logic              first_q, first_d;
  logic              lap2_q, lap2_d;
  logic              found_q, found_d;
  logic [IDX_W-1:0]  start_q, start_d;
  logic [DIST_W-1:0] pd_q, pd_d;      // forward: pending distance of prev
  logic [LAB_W-1:0]  pl_q, pl_d;      // forward: label of prev
  logic [DIST_W-1:0] nd_q, nd_d;      // backward: distance of the next voxel
  logic [LAB_W-1:0]  lab_rd_q;
  logic [DIST_W-1:0] dist_rd_q;

  logic              out_valid_q, out_valid_d;
  logic [5:0]        out_dist_q;
  logic              out_inf_q, out_last_q;

  logic [ROW_W-1:0]  n_eff, count_inc;
  logic [IDX_W-1:0]  n_m1, n_m2, nxt_idx, rd_addr, bwd_first;
  logic              is_zero, mismatch, found_now, go2, at_end;
  logic [IDX_W-1:0]  start_now;
  logic [DIST_W-1:0] cd, bwd_new;
  logic              dwe;
  logic [IDX_W-1:0]  dwaddr;
  logic [DIST_W-1:0] dwdata;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      multi_q   <= 1'b0;
      toric_q   <= 1'b0;
      row_len_q <= ROW_W'(64);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_MULTIREGION: multi_q   <= cfg_wdata_i[0];
        CFG_TORIC:       toric_q   <= cfg_wdata_i[0];
        CFG_ROW_LENGTH:  row_len_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (row_len_q == '0) begin
      n_eff = ROW_W'(1);
    end else if (row_len_q > ROW_W'(MAX_ROW)) begin
      n_eff = ROW_W'(MAX_ROW);
    end else begin
      n_eff = row_len_q;
    end
  end

  assign count_inc = count_q + ROW_W'(1);
  assign n_m1      = IDX_W'(n_q - ROW_W'(1));
  assign n_m2      = IDX_W'(n_q - ROW_W'(2));
  assign nxt_idx   = (idx_q == n_m1) ? '0 : idx_q + IDX_W'(1);
  assign rd_addr   = cmd_i.rd_nxt ? nxt_idx : idx_q;
  assign bwd_first = !toric_q ? n_m2 : ((start_q == '0) ? n_m1 : start_q - IDX_W'(1));

  // forward element
  assign is_zero   = (lab_rd_q == '0);
  assign mismatch  = (pl_q != lab_rd_q);
  assign found_now = found_q || is_zero;
  assign start_now = found_q ? start_q : idx_q;
  assign go2       = toric_q && !multi_q && found_now && (start_now != '0);
  assign at_end    = lap2_q ? (idx_q == start_q - IDX_W'(1)) : (idx_q == n_m1);

  always_comb begin
    if (first_q) begin
      cd = (multi_q || is_zero) ? '0 : DIST_INF;
    end else if (!multi_q) begin
      cd = is_zero ? '0 : inc_sat(pd_q);
    end else begin
      cd = mismatch ? '0 : inc_sat(pd_q);
    end
  end

  assign bwd_new = (nd_q < dist_rd_q) ? inc_sat(nd_q) : dist_rd_q;

  always_comb begin
    dwe    = 1'b0;
    dwaddr = prev_q;
    dwdata = pd_q;
    if (cmd_i.fwd_step) begin
      dwe    = !first_q;
      dwdata = (multi_q && mismatch) ? '0 : pd_q;
    end else if (cmd_i.flush) begin
      dwe    = 1'b1;
      dwdata = multi_q ? '0 : pd_q;   // multiregion: last voxel is a border
    end else if (cmd_i.bwd_step) begin
      dwe    = 1'b1;
      dwaddr = idx_q;
      dwdata = bwd_new;
    end
  end

  always_comb begin
    count_d = count_q;
    n_d     = n_q;
    idx_d   = idx_q;
    prev_d  = prev_q;
    steps_d = steps_q;
    first_d = first_q;
    lap2_d  = lap2_q;
    found_d = found_q;
    start_d = start_q;
    pd_d    = pd_q;
    pl_d    = pl_q;
    nd_d    = nd_q;

    if (cmd_i.load_wr) begin
      if (count_inc >= n_eff) begin
        count_d = '0;
        n_d     = n_eff;
        idx_d   = '0;
        first_d = 1'b1;
        lap2_d  = 1'b0;
        found_d = 1'b0;
        start_d = '0;
      end else begin
        count_d = count_inc;
      end
    end

    if (cmd_i.fwd_step) begin
      pd_d    = cd;
      pl_d    = lab_rd_q;
      prev_d  = idx_q;
      first_d = 1'b0;
      if (!multi_q && !lap2_q && is_zero && !found_q) begin
        found_d = 1'b1;
        start_d = idx_q;
      end
      if (at_end && !lap2_q && go2) begin
        lap2_d = 1'b1;
        idx_d  = '0;
      end else begin
        idx_d  = idx_q + IDX_W'(1);
      end
    end

    if (cmd_i.flush) begin
      idx_d   = bwd_first;
      steps_d = n_q - ROW_W'(1);
    end

    if (cmd_i.bwd_init) nd_d = dist_rd_q;

    if (cmd_i.bwd_step) begin
      nd_d    = bwd_new;
      idx_d   = (idx_q == '0) ? n_m1 : idx_q - IDX_W'(1);
      steps_d = steps_q - ROW_W'(1);
    end

    if (cmd_i.out_load) idx_d = idx_q + IDX_W'(1);
    if (cmd_i.out_init) idx_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      n_q         <= ROW_W'(1);
      idx_q       <= '0;
      prev_q      <= '0;
      steps_q     <= '0;
      first_q     <= 1'b1;
      lap2_q      <= 1'b0;
      found_q     <= 1'b0;
      start_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      n_q         <= n_d;
      idx_q       <= idx_d;
      prev_q      <= prev_d;
      steps_q     <= steps_d;
      first_q     <= first_d;
      lap2_q      <= lap2_d;
      found_q     <= found_d;
      start_q     <= start_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pd_q <= pd_d;
    pl_q <= pl_d;
    nd_q <= nd_d;
  end

  // stores
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_wr) label_mem[count_q[IDX_W-1:0]] <= label_i[LAB_W-1:0];
    if (cmd_i.lab_rd) lab_rd_q <= label_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (dwe) dist_mem[dwaddr] <= dwdata;
    if (cmd_i.dist_rd) dist_rd_q <= dist_mem[rd_addr];
  end

  // output register
  assign out_valid_d = cmd_i.out_load ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_inf_q  <= dist_rd_q[DIST_W-1];
      out_dist_q <= dist_rd_q[DIST_W-1] ? 6'h3F : dist_rd_q[5:0];
      out_last_q <= (idx_q == n_m1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_dist_o  = out_dist_q;
  assign out_inf_o   = out_inf_q;
  assign out_last_o  = out_last_q;

  assign status_o.load_last = (count_inc >= n_eff);
  assign status_o.fwd_last  = at_end && (lap2_q || !go2);
  assign status_o.n_one     = (n_q == ROW_W'(1));
  assign status_o.bwd_last  = (steps_q == ROW_W'(1));
  assign status_o.out_last  = (idx_q == n_m1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;

endmodule

### rtl/row_distance_transform_top.sv
// Top level of the row distance transform: controller plus datapath.
// Depends on rdt_pkg, rdt_ctrl and rdt_datapath.
//
// Usage:
//   s_axis carries one voxel label per transfer (tdata[7:0]) in row order.
//   The row ends when the load count reaches row_length (0 acts as 1, above
//   64 acts as 64). Configuration writes go through cfg_we_i/cfg_index_i/
//   cfg_wdata_i while the block is idle.
//   m_axis emits one result per voxel in order: tdata[5:0] distance,
//   tuser[0] infinite flag, tlast on the final voxel of the row.
// Sequence:
//   Loading takes one voxel per cycle. After the last voxel the forward
//   scan reads and then processes each voxel (a second partial lap in
//   toric plain mode), a flush step follows, then the backward scan reads
//   and then processes each voxel, then emission reads and then loads
//   each result. A one-voxel row skips the backward scan. Each step reads
//   first because the two stores have registered reads.
//   s_axis_tready is high only while a row is being loaded.
// Reset: registers return to defaults (row_length 64), load count clears.
//   The stores are not cleared. A stalled receiver holds the output
//   register and the emission sequence waits; loading of the next row may
//   start while the final result still waits.
module row_distance_transform_top
  import rdt_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_index_i,
  input  logic [ROW_W-1:0] cfg_wdata_i,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [7:0]       s_axis_tdata,   // [7:0] voxel_label
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [7:0]       m_axis_tdata,   // [5:0] distance, [7:6] zero
  output logic [0:0]       m_axis_tuser,   // [0] is_infinite
  output logic             m_axis_tlast
);

  rdt_cmd_t    cmd;
  rdt_status_t status;
  logic [5:0]  out_dist;
  logic        out_inf;

  rdt_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .status_i  (status),
    .cmd_o     (cmd)
  );

  rdt_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .label_i     (s_axis_tdata),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_dist_o  (out_dist),
    .out_inf_o   (out_inf),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, out_dist};
  assign m_axis_tuser = out_inf;

endmodule

### rtl/rdt_checker.sv
// Port-level checks for row_distance_transform_top, bound to the top level.
// Imports rdt_pkg; the port widths are written out as literals.
module rdt_checker
  import rdt_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             s_axis_tready,
  input logic             m_axis_tvalid,
  input logic             m_axis_tready,
  input logic [7:0]       m_axis_tdata,
  input logic [0:0]       m_axis_tuser,
  input logic             m_axis_tlast
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
      && $stable(m_axis_tlast))
    else $error("output changed while stalled");

  // an infinite result carries the saturated distance
  a_inf_sat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[5:0] == 6'h3F)
    else $error("infinite result without saturated distance");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[7:6] == 2'b00)
    else $error("tdata padding not zero");

  // the input stays closed while a row is still being emitted
  a_no_load_mid_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("input open during row emission");

endmodule

bind row_distance_transform_top rdt_checker u_rdt_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

### tb/tb.sv
// Self-checking testbench for row_distance_transform_top: directed table, then random rows
// under several idle/stall mixes, checked against the table or an in-bench distance model.
// Depends on rdt_pkg and the RTL under rtl/.
module tb;
  import rdt_pkg::*;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int DRAIN_CYCLES = 7 * MAX_ROW + 10;
  localparam int RAND_PHASES  = 12;
  localparam int PHASE_ITEMS  = 22;

  typedef enum int {
    ROW_SPARSE_ZERO,
    ROW_NO_ZERO,
    ROW_RUNS,
    ROW_MOSTLY_ZERO
  } row_style_e;

  typedef struct packed {
    logic [7:0] data;
    logic       inf;
    logic       last;
  } dist_res_t;

  typedef struct packed {
    logic       is_cfg;
    logic [1:0] idx;
    logic [6:0] val;
    logic [7:0] label;
    logic       typed;
    logic [5:0] t_dist;
    logic       t_inf;
  } stim_row_t;

  logic             clk_i;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_index_i = '0;
  logic [ROW_W-1:0] cfg_wdata_i = '0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [7:0]       s_axis_tdata = '0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [7:0]       m_axis_tdata;
  logic [0:0]       m_axis_tuser;
  logic             m_axis_tlast;

  row_distance_transform_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // [7:0] voxel_label
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // [5:0] distance, [7:6] zero
    .m_axis_tuser  (m_axis_tuser),   // [0] is_infinite
    .m_axis_tlast  (m_axis_tlast)
  );

  dist_res_t exp_dist_q[$];
  dist_res_t mon_exp;
  int        err_count = 0;
  int        snd_idle_pct = 0;
  int        rcv_stall_pct = 0;

  // predictor state
  logic [LAB_W-1:0]  row_labels [MAX_ROW];
  logic [DIST_W-1:0] row_dist [MAX_ROW];
  int                fill_cnt = 0;
  logic              mode_multi = 1'b0;
  logic              mode_toric = 1'b0;
  logic [ROW_W-1:0]  len_reg = ROW_W'(64);

  stim_row_t  stim_tab[$];
  int         p, items, n, k;
  row_style_e style;
  logic [7:0] lab;

  function automatic logic [DIST_W-1:0] dist_inc(input logic [DIST_W-1:0] d);
    if (d >= DIST_INF - 1) begin
      return DIST_INF;
    end
    return d + 1'b1;
  endfunction

  function automatic int eff_len();
    if (len_reg == 0) begin
      return 1;
    end
    if (int'(len_reg) > MAX_ROW) begin
      return MAX_ROW;
    end
    return int'(len_reg);
  endfunction

  // forward scan from the first border, then backward relaxation
  function automatic void scan_row(input int len);
    int start, cur, prev, steps, nxt, j;
    start = 0;
    if (!mode_multi) begin
      while (start < len && row_labels[start] != 0) begin
        row_dist[start] = DIST_INF;
        start++;
      end
    end
    if (start >= len) begin
      return;
    end
    row_dist[start] = '0;
    cur = (start + 1) % len;
    prev = start;
    steps = mode_toric ? len : len - start;
    for (j = 1; j < steps; j++) begin
      if (!mode_multi) begin
        if (row_labels[cur] == 0) begin
          row_dist[cur] = '0;
        end else begin
          row_dist[cur] = dist_inc(row_dist[prev]);
        end
      end else if (row_labels[prev] == row_labels[cur]) begin
        row_dist[cur] = dist_inc(row_dist[prev]);
      end else begin
        row_dist[cur] = '0;
        row_dist[prev] = '0;
      end
      prev = cur;
      cur = (cur + 1) % len;
    end
    if (mode_multi) begin
      row_dist[len-1] = '0;
    end
    if (len < 2) begin
      return;
    end
    cur = mode_toric ? (start + len - 1) % len : len - 2;
    for (j = 0; j + 1 < len; j++) begin
      nxt = (cur + 1) % len;
      if (row_dist[nxt] < row_dist[cur]) begin
        row_dist[cur] = dist_inc(row_dist[nxt]);
      end
      cur = (cur + len - 1) % len;
    end
  endfunction

  function automatic void predict_voxel(input logic [7:0] label);
    int        len, j;
    dist_res_t r;
    len = eff_len();
    if (fill_cnt >= MAX_ROW) begin
      fill_cnt = MAX_ROW - 1;
    end
    row_labels[fill_cnt] = label[LAB_W-1:0];
    fill_cnt++;
    if (fill_cnt < len) begin
      return;
    end
    fill_cnt = 0;
    scan_row(len);
    for (j = 0; j < len; j++) begin
      r.inf  = (row_dist[j] >= 64);
      r.data = r.inf ? 8'd63 : {2'b00, row_dist[j][5:0]};
      r.last = (j == len - 1);
      exp_dist_q.push_back(r);
    end
  endfunction

  function automatic stim_row_t reg_row(input logic [1:0] idx, input logic [6:0] val);
    stim_row_t r;
    r = '0;
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    return r;
  endfunction

  function automatic stim_row_t vox_row(input logic [7:0] label);
    stim_row_t r;
    r = '0;
    r.label = label;
    return r;
  endfunction

  function automatic stim_row_t vox_exp(input logic [7:0] label, input logic [5:0] want_dist,
                                        input logic inf);
    stim_row_t r;
    r = vox_row(label);
    r.typed = 1'b1;
    r.t_dist = want_dist;
    r.t_inf = inf;
    return r;
  endfunction

  function automatic logic [7:0] pick_label(input row_style_e st, input logic [7:0] prv);
    case (st)
      ROW_SPARSE_ZERO: return ($urandom_range(7) == 0) ? 8'h00 : 8'($urandom_range(255));
      ROW_NO_ZERO:     return 8'($urandom_range(255, 1));
      ROW_RUNS: begin
        if ($urandom_range(3) != 0) begin
          return prv;
        end
        return ($urandom_range(5) == 0) ? 8'h00 : 8'($urandom_range(255));
      end
      default:         return ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : 8'h00;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input int want, input int got);
    $display("MISMATCH %s: expected 0x%0h, got 0x%0h (t=%0t)", what, want, got, $time);
    err_count++;
  endtask

  task automatic send_voxel(input logic [7:0] label);
    while ($urandom_range(99) < snd_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= label;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_voxel(label);
  endtask

  // hold the sender until every result is out and the block has settled
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (exp_dist_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [6:0] val);
    wait_idle();
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_MULTIREGION: mode_multi = val[0];
      CFG_TORIC:       mode_toric = val[0];
      CFG_ROW_LENGTH:  len_reg = val;
      default: ;
    endcase
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= rcv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (exp_dist_q.size() == 0) begin
        report_mismatch("result with none expected", 0,
                        {m_axis_tdata, m_axis_tuser, m_axis_tlast});
      end else begin
        mon_exp = exp_dist_q.pop_front();
        if (m_axis_tdata !== mon_exp.data) begin
          report_mismatch("distance", mon_exp.data, m_axis_tdata);
        end
        if (m_axis_tuser[0] !== mon_exp.inf) begin
          report_mismatch("is_infinite", mon_exp.inf, m_axis_tuser[0]);
        end
        if (m_axis_tlast !== mon_exp.last) begin
          report_mismatch("last", mon_exp.last, m_axis_tlast);
        end
      end
    end
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    // single-voxel rows: results follow directly from the label and mode
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd1));
    stim_tab.push_back(vox_exp(8'h00, 6'd0, 1'b0));
    stim_tab.push_back(vox_exp(8'hFF, 6'd63, 1'b1));   // no border at all
    stim_tab.push_back(vox_exp(8'h01, 6'd63, 1'b1));
    stim_tab.push_back(reg_row(CFG_MULTIREGION, 7'd1));
    stim_tab.push_back(vox_exp(8'hFF, 6'd0, 1'b0));    // row ends are borders
    stim_tab.push_back(reg_row(CFG_TORIC, 7'd1));
    stim_tab.push_back(vox_exp(8'h00, 6'd0, 1'b0));
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd0)); // zero length acts as one
    stim_tab.push_back(vox_exp(8'hAA, 6'd0, 1'b0));
    stim_tab.push_back(reg_row(CFG_MULTIREGION, 7'd0));
    stim_tab.push_back(vox_exp(8'h55, 6'd63, 1'b1));
    stim_tab.push_back(reg_row(CFG_UNUSED, 7'h7F));    // must be ignored
    stim_tab.push_back(vox_exp(8'h00, 6'd0, 1'b0));
    // short rows in each mode
    stim_tab.push_back(reg_row(CFG_TORIC, 7'd0));
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd4));
    stim_tab.push_back(vox_row(8'h05));
    stim_tab.push_back(vox_row(8'h00));
    stim_tab.push_back(vox_row(8'h05));
    stim_tab.push_back(vox_row(8'h05));
    stim_tab.push_back(reg_row(CFG_TORIC, 7'd1));
    stim_tab.push_back(vox_row(8'h07));
    stim_tab.push_back(vox_row(8'h07));
    stim_tab.push_back(vox_row(8'h00));
    stim_tab.push_back(vox_row(8'h07));
    stim_tab.push_back(reg_row(CFG_MULTIREGION, 7'd1)); // toric multiregion
    stim_tab.push_back(vox_row(8'h03));
    stim_tab.push_back(vox_row(8'h03));
    stim_tab.push_back(vox_row(8'h09));
    stim_tab.push_back(vox_row(8'h09));
    stim_tab.push_back(reg_row(CFG_TORIC, 7'd0));
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd3));
    stim_tab.push_back(vox_row(8'h01));
    stim_tab.push_back(vox_row(8'h01));
    stim_tab.push_back(vox_row(8'h01));
    // length drops below the load count mid-row: next voxel closes the row
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd8));
    stim_tab.push_back(vox_row(8'h04));
    stim_tab.push_back(vox_row(8'h04));
    stim_tab.push_back(vox_row(8'h04));
    stim_tab.push_back(reg_row(CFG_ROW_LENGTH, 7'd2));
    stim_tab.push_back(vox_row(8'h04));

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_tab[i]) begin
      if (stim_tab[i].is_cfg) begin
        write_reg(stim_tab[i].idx, stim_tab[i].val);
      end else begin
        send_voxel(stim_tab[i].label);
        if (stim_tab[i].typed) begin
          exp_dist_q[exp_dist_q.size()-1] = '{data: {2'b00, stim_tab[i].t_dist},
                                              inf: stim_tab[i].t_inf, last: 1'b1};
        end
      end
    end

    for (p = 0; p < RAND_PHASES; p++) begin
      case (p % 4)
        0: begin snd_idle_pct = 0;  rcv_stall_pct = 0;  end
        1: begin snd_idle_pct = 79; rcv_stall_pct = 0;  end
        2: begin snd_idle_pct = 0;  rcv_stall_pct = 79; end
        default: begin snd_idle_pct = 37; rcv_stall_pct = 37; end
      endcase
      if (p < 4) begin
        write_reg(CFG_MULTIREGION, 7'(p & 1));
        write_reg(CFG_TORIC, 7'((p >> 1) & 1));
      end else begin
        write_reg(CFG_MULTIREGION, 7'($urandom_range(1)));
        write_reg(CFG_TORIC, 7'($urandom_range(1)));
      end
      case (p)
        0: write_reg(CFG_ROW_LENGTH, 7'd127);   // clamps to the maximum row
        1: write_reg(CFG_ROW_LENGTH, 7'd1);
        2: write_reg(CFG_ROW_LENGTH, 7'd2);
        3: write_reg(CFG_ROW_LENGTH, 7'd63);
        4: write_reg(CFG_ROW_LENGTH, 7'd64);
        5: write_reg(CFG_ROW_LENGTH, 7'd0);
        6: write_reg(CFG_ROW_LENGTH, 7'($urandom_range(64, 1)));
        default: write_reg(CFG_ROW_LENGTH, 7'($urandom_range(16, 3)));
      endcase
      items = 0;
      while (items < PHASE_ITEMS) begin
        n = eff_len();
        style = row_style_e'($urandom_range(3));
        lab = 8'($urandom_range(255));
        for (k = 0; k < n; k++) begin
          lab = pick_label(style, lab);
          send_voxel(lab);
          items++;
        end
        if ($urandom_range(7) == 0) begin
          s_axis_tvalid <= 1'b0;
          while (exp_dist_q.size() != 0) @(posedge clk_i);
        end
      end
    end

    wait_idle();
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
